/* src/myb_pkg.sv */
// ----------------------------------------------------------------------------
// myb_pkg: shared types and constants of the masked 4:2:0 blender
// Holds the item classification codes, the configuration register indexes,
// the queue entry layout and the 8-bit blend function.
// ----------------------------------------------------------------------------
package myb_pkg;

    typedef enum logic {
        OP_LUMA   = 1'b0,
        OP_CHROMA = 1'b1
    } op_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd320;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd240;

    localparam logic [7:0] MASK_FULL = 8'd255;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // One classified item, as it travels from the front to the back.
    typedef struct packed {
        op_t        kind;
        logic       wr;         // write a group sum
        logic       accum;      // add to the stored sum instead of overwriting
        logic       frame_end;
        logic [8:0] pair;       // mask sum of a horizontal pixel pair
        logic [7:0] mask;       // luma mask
        logic [7:0] a0;
        logic [7:0] b0;
        logic [7:0] a1;
        logic [7:0] b1;
    } item_t;

    function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] m);
        logic [15:0] pa;
        logic [15:0] pb;
        logic [15:0] s;
        pa = 16'(a) * 16'(m);
        pb = 16'(b) * 16'(MASK_FULL - m);
        s  = pa + pb;
        return s[15:8];
    endfunction

endpackage

/* src/masked_yuv420_blend.sv */
// ----------------------------------------------------------------------------
// masked_yuv420_blend: masked blend of two planar 4:2:0 frames
// Luma items blend under their own mask and build 2x2 mask group sums;
// chroma items blend U and V under the average of their group.
// ----------------------------------------------------------------------------
// Path: an item passes through the queue, the store read stage and the
//   output register before its result is presented.
// Throughput: one item per cycle unless stalled (one-read/one-write store).
// Reset: counters and pending mask clear, frame size returns to 320 x 240;
//   the group store is not cleared, so a chroma read of a group never written
//   since reset returns an undefined mask.
// ----------------------------------------------------------------------------
module masked_yuv420_blend
    import myb_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input item channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [7:0]            luma_a,
    input  logic [7:0]            luma_b,
    input  logic [7:0]            mask_value,
    input  logic [7:0]            u_a,
    input  logic [7:0]            u_b,
    input  logic [7:0]            v_a,
    input  logic [7:0]            v_b,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  kind,
    output logic [7:0]            luma_out,
    output logic [7:0]            u_out,
    output logic [7:0]            v_out,
    output logic                  frame_end
);

    localparam int GROUP_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
    localparam int ADDR_W      = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam int ENTRY_W     = $bits(item_t) + ADDR_W;

    logic [CFG_DATA_W-1:0] frame_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;

    logic                  push;
    item_t                 push_item;
    logic [ADDR_W-1:0]     push_addr;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    logic [ENTRY_W-1:0]    q_head;
    item_t                 q_item;
    logic [ADDR_W-1:0]     q_addr;

    // Configuration writes are registered; accept every transaction and
    // drop writes to indexes outside the register list.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Front: accept each transaction, advance the frame position and turn
    // the item into a queue entry that names its group store address.
    myb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .luma_a       (luma_a),
        .luma_b       (luma_b),
        .mask_value   (mask_value),
        .u_a          (u_a),
        .u_b          (u_b),
        .v_a          (v_a),
        .v_b          (v_b),
        .q_full       (q_full),
        .push         (push),
        .push_item    (push_item),
        .push_addr    (push_addr)
    );

    // Queue: decouple intake from the store and the output stall.
    myb_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_addr, push_item}),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    assign q_item = item_t'(q_head[$bits(item_t)-1:0]);
    assign q_addr = q_head[ENTRY_W-1:$bits(item_t)];

    // Back: read or update the group store, blend, and hold the result in
    // the output register until the result transaction completes.
    myb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_addr    (q_addr),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .luma_out  (luma_out),
        .u_out     (u_out),
        .v_out     (v_out),
        .frame_end (frame_end)
    );

endmodule

/* src/myb_fifo.sv */
// ----------------------------------------------------------------------------
// myb_fifo: short queue between the front and the back
// Register-based first-in first-out queue of QUEUE_DEPTH entries.
// ----------------------------------------------------------------------------
module myb_fifo
    import myb_pkg::*;
#(
    parameter int WIDTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0]       slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;

    assign full       = (count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/myb_front.sv */
// ----------------------------------------------------------------------------
// myb_front: item intake and classification
// Tracks the luma position, the pending left-pixel mask and the chroma index,
// and turns each accepted item into a queue entry with its group address.
// ----------------------------------------------------------------------------
module myb_front
    import myb_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CFG_DATA_W-1:0] frame_width,
    input  logic [CFG_DATA_W-1:0] frame_height,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [7:0]            luma_a,
    input  logic [7:0]            luma_b,
    input  logic [7:0]            mask_value,
    input  logic [7:0]            u_a,
    input  logic [7:0]            u_b,
    input  logic [7:0]            v_a,
    input  logic [7:0]            v_b,
    input  logic                  q_full,
    output logic                  push,
    output item_t                 push_item,
    output logic [((MAX_WIDTH/2)*(MAX_HEIGHT/2) > 1 ?
                   $clog2((MAX_WIDTH/2)*(MAX_HEIGHT/2)) : 1)-1:0] push_addr
);

    localparam int GROUP_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
    localparam int ADDR_W      = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
    localparam int WD_W        = $clog2(MAX_WIDTH + 1);
    localparam int HD_W        = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);

    logic [WD_W-1:0]   w;
    logic [HD_W-1:0]   h;
    logic [WD_W-2:0]   w2;
    logic [HD_W-2:0]   h2;
    logic [ADDR_W:0]   total;

    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [7:0]        pending_reg;
    logic [7:0]        pending_next;
    logic [ADDR_W-1:0] chroma_reg;
    logic [ADDR_W-1:0] chroma_next;

    logic [COL_W-1:0]  col_eff;
    logic [ROW_W-1:0]  row_eff;
    logic              store_ok;
    logic [ADDR_W-1:0] group_addr;
    logic [WD_W-1:0]   col_inc;
    logic [HD_W-1:0]   row_inc;
    logic [ADDR_W-1:0] ci_eff;
    logic [ADDR_W:0]   ci_inc;
    logic              last_group;

    // Saturate the frame size to the supported range.
    always_comb
    begin
        if (frame_width < 11'd2)
        begin
            w = WD_W'(2);
        end
        else if (32'(frame_width) > MAX_WIDTH)
        begin
            w = WD_W'(MAX_WIDTH);
        end
        else
        begin
            w = WD_W'(frame_width);
        end
        if (frame_height < 11'd2)
        begin
            h = HD_W'(2);
        end
        else if (32'(frame_height) > MAX_HEIGHT)
        begin
            h = HD_W'(MAX_HEIGHT);
        end
        else
        begin
            h = HD_W'(frame_height);
        end
    end

    assign w2    = w[WD_W-1:1];
    assign h2    = h[HD_W-1:1];
    assign total = (ADDR_W + 1)'(w2) * (ADDR_W + 1)'(h2);

    assign push     = in_valid && !q_full;
    assign in_stall = q_full;

    // Luma position and group address; restart a position left beyond the frame.
    always_comb
    begin
        if (row_reg >= h || col_reg >= w)
        begin
            row_eff = '0;
            col_eff = '0;
        end
        else
        begin
            row_eff = row_reg;
            col_eff = col_reg;
        end
        store_ok   = ((col_eff >> 1) < w2) && ((row_eff >> 1) < h2);
        group_addr = ADDR_W'(row_eff >> 1) * ADDR_W'(w2) + ADDR_W'(col_eff >> 1);
        col_inc    = WD_W'(col_eff) + 1'b1;
        row_inc    = HD_W'(row_eff) + 1'b1;
        if (col_inc >= w)
        begin
            col_next = '0;
            row_next = (row_inc >= h) ? '0 : ROW_W'(row_inc);
        end
        else
        begin
            col_next = COL_W'(col_inc);
            row_next = row_eff;
        end
    end

    // Chroma index with wrap at the end of the quarter-size plane.
    always_comb
    begin
        ci_eff      = (chroma_reg >= total) ? '0 : chroma_reg;
        ci_inc      = {1'b0, ci_eff} + 1'b1;
        last_group  = (ci_inc >= total);
        chroma_next = last_group ? '0 : ci_inc[ADDR_W-1:0];
    end

    assign pending_next = (store_ok && !col_eff[0]) ? mask_value : pending_reg;

    always_comb
    begin
        push_item = '0;
        push_addr = '0;
        if (op_t'(op) == OP_CHROMA)
        begin
            push_item.kind      = OP_CHROMA;
            push_item.frame_end = last_group;
            push_item.a0        = u_a;
            push_item.b0        = u_b;
            push_item.a1        = v_a;
            push_item.b1        = v_b;
            push_addr           = ci_eff;
        end
        else
        begin
            push_item.kind  = OP_LUMA;
            push_item.wr    = store_ok && col_eff[0];
            push_item.accum = row_eff[0];
            push_item.pair  = {1'b0, pending_reg} + {1'b0, mask_value};
            push_item.mask  = mask_value;
            push_item.a0    = luma_a;
            push_item.b0    = luma_b;
            push_addr       = group_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            pending_reg <= '0;
            chroma_reg  <= '0;
        end
        else if (push)
        begin
            if (op_t'(op) == OP_CHROMA)
            begin
                chroma_reg <= chroma_next;
            end
            else
            begin
                col_reg     <= col_next;
                row_reg     <= row_next;
                pending_reg <= pending_next;
            end
        end
    end

endmodule

/* src/myb_back.sv */
// ----------------------------------------------------------------------------
// myb_back: group store, blend datapath and output register
// Reads or updates the mask group store, blends luma or chroma and holds
// the result until the output transaction completes.
// ----------------------------------------------------------------------------
module myb_back
    import myb_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    input  logic [((MAX_WIDTH/2)*(MAX_HEIGHT/2) > 1 ?
                   $clog2((MAX_WIDTH/2)*(MAX_HEIGHT/2)) : 1)-1:0] q_addr,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  luma_out,
    output logic [7:0]  u_out,
    output logic [7:0]  v_out,
    output logic        frame_end
);

    localparam int GROUP_DEPTH = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
    localparam int ADDR_W      = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;

    logic [9:0]        group_mem [GROUP_DEPTH];

    logic              s1_valid_reg;
    item_t             s1_item_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [9:0]        rd_data_reg;
    logic              fwd_hit_reg;
    logic [9:0]        fwd_data_reg;

    logic              out_valid_reg;
    logic              kind_reg;
    logic [7:0]        luma_reg;
    logic [7:0]        u_reg;
    logic [7:0]        v_reg;
    logic              frame_end_reg;

    logic              adv;
    logic              mem_wr;
    logic [9:0]        group_sum;
    logic [9:0]        sum_new;
    logic [7:0]        chroma_mask;

    assign adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign pop    = q_valid && (!s1_valid_reg || adv);
    assign mem_wr = adv && s1_item_reg.wr;

    // Bypass the store when the entry was written by the item just ahead.
    assign group_sum   = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign sum_new     = s1_item_reg.accum ? (group_sum + {1'b0, s1_item_reg.pair})
                                           : {1'b0, s1_item_reg.pair};
    assign chroma_mask = group_sum[9:2];

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            group_mem[s1_addr_reg] <= sum_new;
        end
        if (pop)
        begin
            rd_data_reg  <= group_mem[q_addr];
            fwd_data_reg <= sum_new;
            s1_item_reg  <= q_item;
            s1_addr_reg  <= q_addr;
        end
        if (adv)
        begin
            kind_reg      <= s1_item_reg.kind;
            frame_end_reg <= s1_item_reg.frame_end;
            if (s1_item_reg.kind == OP_CHROMA)
            begin
                luma_reg <= '0;
                u_reg    <= blend8(s1_item_reg.a0, s1_item_reg.b0, chroma_mask);
                v_reg    <= blend8(s1_item_reg.a1, s1_item_reg.b1, chroma_mask);
            end
            else
            begin
                luma_reg <= blend8(s1_item_reg.a0, s1_item_reg.b0, s1_item_reg.mask);
                u_reg    <= '0;
                v_reg    <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= mem_wr && (s1_addr_reg == q_addr);
            end
            else if (adv)
            begin
                s1_valid_reg <= 1'b0;
                fwd_hit_reg  <= 1'b0;
            end
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign luma_out  = luma_reg;
    assign u_out     = u_reg;
    assign v_out     = v_reg;
    assign frame_end = frame_end_reg;

`ifndef ASSERT_OFF
    a_s1_holds_under_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |=>
            (s1_valid_reg && $stable(s1_addr_reg) && $stable(s1_item_reg)))
        else $error("stage item changed while output was stalled");

    a_bypass_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("store bypass set without an item in the stage");

    a_bypass_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !(mem_wr && (s1_addr_reg == q_addr))) |=> !fwd_hit_reg)
        else $error("store bypass set without a write to the same entry");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");
`endif

endmodule
